/* hw/rtl/slq_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// slq_pkg
// Shared types, constants and helpers for the 16-bit SUBLEQ machine.
// ----------------------------------------------------------------------------
package slq_pkg;

  // Word memory geometry; the depth is a power of two so fetch addresses wrap.
  localparam int MEM_AW    = 15;
  localparam int MEM_WORDS = 2 ** MEM_AW;
  localparam int WORD_W    = 16;
  localparam int PC_W      = 15;
  localparam int IVAL_W    = 9;

  // Execution stops once the program counter reaches this value.
  localparam logic [PC_W-1:0] PC_LIMIT = 15'd32767;
  localparam logic [PC_W-1:0] PC_MAX   = 15'h7FFF;

  localparam logic [WORD_W-1:0] WORD_M1 = 16'hFFFF;

  typedef enum logic [1:0] {
    CMD_WRITE   = 2'd0,
    CMD_READ    = 2'd1,
    CMD_STEP    = 2'd2,
    CMD_RESTART = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_PC_RANGE  = 3'd1,
    ST_IO_FAULT  = 3'd2,
    ST_BAD_ADDR  = 3'd3,
    ST_HALTED    = 3'd4
  } status_t;

  typedef struct packed {
    logic                   en;
    logic                   we;
    logic [MEM_AW-1:0]      addr;
    logic [WORD_W-1:0]      wdata;
  } mem_req_t;

  typedef struct packed {
    status_t                status;
    logic [PC_W-1:0]        pc;
    logic                   ovalid;
    logic [7:0]             obyte;
    logic                   itaken;
    logic [WORD_W-1:0]      rdata;
  } result_t;

  // True when a signed memory word names an existing memory entry.
  function automatic logic word_addr_ok(input logic [WORD_W-1:0] x);
    return !x[WORD_W-1] && ({1'b0, x} < 17'(MEM_WORDS));
  endfunction

  // True when a command address names an existing memory entry.
  function automatic logic cmd_addr_ok(input logic [PC_W-1:0] x);
    return {2'b00, x} < 17'(MEM_WORDS);
  endfunction

endpackage : slq_pkg
`default_nettype wire

/* hw/rtl/slq_ram.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// slq_ram
// Single-port synchronous RAM, read-first, with a registered read port.
// ----------------------------------------------------------------------------
module slq_ram #(
  parameter int AW = 15,
  parameter int DW = 16
) (
  input  wire logic          clk,
  input  wire logic          en,
  input  wire logic          we,
  input  wire logic [AW-1:0] addr,
  input  wire logic [DW-1:0] wdata,
  output logic      [DW-1:0] rdata
);

  logic [DW-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end
      rdata <= mem[addr];
    end
  end

endmodule : slq_ram
`default_nettype wire

/* hw/rtl/slq_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// slq_ctrl
// Command sequencer: fetches operands, reads, modifies and writes back memory.
// ----------------------------------------------------------------------------
module slq_ctrl (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [1:0]                    in_cmd,
  input  wire logic [slq_pkg::PC_W-1:0]      in_addr,
  input  wire logic [slq_pkg::WORD_W-1:0]    in_wdata,
  input  wire logic [slq_pkg::IVAL_W-1:0]    in_ival,
  output slq_pkg::mem_req_t                  mem,
  input  wire logic [slq_pkg::WORD_W-1:0]    mem_rdata,
  output logic                               res_valid,
  input  wire logic                          res_ack,
  output slq_pkg::result_t                   res
);
  import slq_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_RDW  = 9'b000000010,
    S_FB   = 9'b000000100,
    S_FC   = 9'b000001000,
    S_DEC  = 9'b000010000,
    S_RA   = 9'b000100000,
    S_RB   = 9'b001000000,
    S_OUTB = 9'b010000000,
    S_RESP = 9'b100000000
  } state_t;

  state_t             state, state_next;
  logic [PC_W-1:0]    pc;
  logic               halted;
  logic [IVAL_W-1:0]  ival;
  logic [WORD_W-1:0]  op_a, op_b, op_c, va;
  status_t            r_status;
  logic               r_ovalid, r_itaken;
  logic [7:0]         r_obyte;
  logic [WORD_W-1:0]  r_rdata;

  cmd_t               cmd;
  logic               accept;
  logic               a_m1, b_m1;
  logic               commit;
  logic [PC_W:0]      npc, pc_plus3;
  logic [PC_W:0]      pc_plus1, pc_plus2;
  logic [WORD_W-1:0]  diff;
  logic               dec_halt;
  status_t            dec_code;
  status_t            acc_status;

  assign cmd      = cmd_t'(in_cmd);
  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign a_m1     = (op_a == WORD_M1);
  assign b_m1     = (op_b == WORD_M1);
  assign pc_plus1 = {1'b0, pc} + 16'd1;
  assign pc_plus2 = {1'b0, pc} + 16'd2;
  assign pc_plus3 = {1'b0, pc} + 16'd3;
  assign diff     = mem_rdata - va;

  // Decode of the fetched instruction; c arrives on the read port in S_DEC.
  always_comb begin
    dec_halt = 1'b0;
    dec_code = ST_OK;
    if (mem_rdata[WORD_W-1]) begin
      dec_halt = 1'b1;
      dec_code = ST_BAD_ADDR;
    end else if (a_m1 && b_m1) begin
      dec_halt = 1'b1;
      dec_code = ST_IO_FAULT;
    end else if (a_m1) begin
      dec_halt = !word_addr_ok(op_b);
      dec_code = ST_BAD_ADDR;
    end else if (b_m1) begin
      dec_halt = !word_addr_ok(op_a);
      dec_code = ST_BAD_ADDR;
    end else begin
      dec_halt = !(word_addr_ok(op_a) && word_addr_ok(op_b));
      dec_code = ST_BAD_ADDR;
    end
  end

  // Status that is already known when a command is taken.
  always_comb begin
    acc_status = ST_OK;
    if ((cmd == CMD_WRITE || cmd == CMD_READ) && !cmd_addr_ok(in_addr)) begin
      acc_status = ST_BAD_ADDR;
    end else if ((cmd == CMD_STEP) && halted) begin
      acc_status = ST_HALTED;
    end else if ((cmd == CMD_STEP) && (pc >= PC_LIMIT)) begin
      acc_status = ST_PC_RANGE;
    end
  end

  always_comb begin
    state_next = state;
    mem        = '0;
    commit     = 1'b0;
    npc        = pc_plus3;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          unique case (cmd)
            CMD_WRITE: begin
              mem.en     = cmd_addr_ok(in_addr);
              mem.we     = cmd_addr_ok(in_addr);
              mem.addr   = in_addr[MEM_AW-1:0];
              mem.wdata  = in_wdata;
              state_next = S_RESP;
            end
            CMD_READ: begin
              mem.en     = cmd_addr_ok(in_addr);
              mem.addr   = in_addr[MEM_AW-1:0];
              state_next = S_RDW;
            end
            CMD_STEP: begin
              if (!halted && (pc < PC_LIMIT)) begin
                mem.en     = 1'b1;
                mem.addr   = pc[MEM_AW-1:0];
                state_next = S_FB;
              end else begin
                state_next = S_RESP;
              end
            end
            CMD_RESTART: state_next = S_RESP;
            default:     state_next = S_RESP;
          endcase
        end
      end
      S_RDW: state_next = S_RESP;
      S_FB: begin
        mem.en     = 1'b1;
        mem.addr   = pc_plus1[MEM_AW-1:0];
        state_next = S_FC;
      end
      S_FC: begin
        mem.en     = 1'b1;
        mem.addr   = pc_plus2[MEM_AW-1:0];
        state_next = S_DEC;
      end
      S_DEC: begin
        if (dec_halt) begin
          state_next = S_RESP;
        end else if (a_m1) begin
          // Input: store the supplied value at b and branch on it.
          mem.en     = 1'b1;
          mem.we     = 1'b1;
          mem.addr   = op_b[MEM_AW-1:0];
          mem.wdata  = {{(WORD_W-IVAL_W){ival[IVAL_W-1]}}, ival};
          commit     = 1'b1;
          npc        = ($signed(ival) > 0) ? pc_plus3 : mem_rdata;
          state_next = S_RESP;
        end else begin
          mem.en     = 1'b1;
          mem.addr   = op_a[MEM_AW-1:0];
          state_next = b_m1 ? S_OUTB : S_RA;
        end
      end
      S_RA: begin
        mem.en     = 1'b1;
        mem.addr   = op_b[MEM_AW-1:0];
        state_next = S_RB;
      end
      S_RB: begin
        mem.en     = 1'b1;
        mem.we     = 1'b1;
        mem.addr   = op_b[MEM_AW-1:0];
        mem.wdata  = diff;
        commit     = 1'b1;
        npc        = ($signed(diff) > 0) ? pc_plus3 : op_c;
        state_next = S_RESP;
      end
      S_OUTB: begin
        commit     = 1'b1;
        npc        = pc_plus3;
        state_next = S_RESP;
      end
      S_RESP: begin
        if (res_ack) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      pc     <= '0;
      halted <= 1'b0;
    end else begin
      state <= state_next;
      if (accept && (cmd == CMD_RESTART)) begin
        pc     <= '0;
        halted <= 1'b0;
      end
      if (accept && (cmd == CMD_STEP) && !halted && (pc >= PC_LIMIT)) begin
        halted <= 1'b1;
      end
      if ((state == S_DEC) && dec_halt) begin
        halted <= 1'b1;
      end
      if (commit) begin
        pc <= (npc > {1'b0, PC_MAX}) ? PC_MAX : npc[PC_W-1:0];
        if (npc >= {1'b0, PC_LIMIT}) begin
          halted <= 1'b1;
        end
      end
    end
  end

  // Operand and result registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      ival     <= in_ival;
      r_status <= acc_status;
      r_ovalid <= 1'b0;
      r_obyte  <= '0;
      r_itaken <= 1'b0;
      r_rdata  <= '0;
    end
    if (state == S_RDW && r_status == ST_OK) begin
      r_rdata <= mem_rdata;
    end
    if (state == S_FB) begin
      op_a <= mem_rdata;
    end
    if (state == S_FC) begin
      op_b <= mem_rdata;
    end
    if (state == S_DEC) begin
      op_c <= mem_rdata;
      if (dec_halt) begin
        r_status <= dec_code;
      end else if (a_m1) begin
        r_itaken <= 1'b1;
      end
    end
    if (state == S_RA) begin
      va <= mem_rdata;
    end
    if (state == S_OUTB) begin
      r_ovalid <= 1'b1;
      r_obyte  <= mem_rdata[7:0];
    end
    if (commit && (npc >= {1'b0, PC_LIMIT})) begin
      r_status <= ST_PC_RANGE;
    end
  end

  assign res_valid  = (state == S_RESP);
  assign res.status = r_status;
  assign res.pc     = pc;
  assign res.ovalid = r_ovalid;
  assign res.obyte  = r_obyte;
  assign res.itaken = r_itaken;
  assign res.rdata  = r_rdata;

`ifndef ASSERT_OFF
  a_we_states: assert property (@(posedge clk) disable iff (rst)
    mem.we |-> (state == S_IDLE || state == S_DEC || state == S_RB))
    else $error("memory write outside a write-back state");

  a_halted_pc: assert property (@(posedge clk) disable iff (rst)
    (halted && !(accept && cmd == CMD_RESTART)) |=> $stable(pc))
    else $error("pc moved while halted");

  a_resp_hold: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_ack) |=> (res_valid && $stable(res)))
    else $error("pending result changed before transfer");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> !in_ready)
    else $error("input taken while a result is pending");
`endif

endmodule : slq_ctrl
`default_nettype wire

/* hw/rtl/subleq_machine_step.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// subleq_machine_step
// 16-bit SUBLEQ machine with a 32K-word memory, driven one command at a time.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake            Payload
//   s_*      in         s_tvalid / s_tready  command in s_tuser, rest in s_tdata
//   m_*      out        m_tvalid / m_tready  one result per command in m_tdata
//
// Every command yields exactly one result transfer. Write, restart and a
// refused step go straight to their result, a read first waits for its data
// word, and a step that fetches its instruction makes three operand fetches,
// then an input write-back or a fault found at decode, one data read for
// output, or two data reads and a write-back for a subtract, all through the
// single port of the word memory.
// Reset clears pc and the halt flag; memory contents are not cleared and a
// word must be written before it is read.
// A result waits in the output register while the next command is already
// being executed; the sequencer stalls only when it has a second result ready.
module subleq_machine_step (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // [14:0] address, [30:15] write_data, [39:31] input_value
  input  wire logic [39:0] s_tdata,
  // [1:0] command
  input  wire logic [1:0]  s_tuser,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // [2:0] status, [17:3] program_counter, [18] output_valid,
  // [26:19] output_byte, [27] input_taken, [43:28] read_data, [47:44] zero
  output logic [47:0]      m_tdata
);
  import slq_pkg::*;

  mem_req_t           mem;
  logic [WORD_W-1:0]  mem_rdata;
  logic               res_valid;
  logic               res_ack;
  result_t            res;
  logic               out_free;

  slq_ram #(
    .AW (MEM_AW),
    .DW (WORD_W)
  ) u_ram (
    .clk   (clk),
    .en    (mem.en),
    .we    (mem.we),
    .addr  (mem.addr),
    .wdata (mem.wdata),
    .rdata (mem_rdata)
  );

  slq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_cmd    (s_tuser),
    .in_addr   (s_tdata[14:0]),
    .in_wdata  (s_tdata[30:15]),
    .in_ival   (s_tdata[39:31]),
    .mem       (mem),
    .mem_rdata (mem_rdata),
    .res_valid (res_valid),
    .res_ack   (res_ack),
    .res       (res)
  );

  // The output register frees up in the same cycle its result transfers.
  assign out_free = !m_tvalid || m_tready;
  assign res_ack  = res_valid && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_free) begin
      m_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ack) begin
      m_tdata <= {4'b0000, res.rdata, res.itaken, res.obyte, res.ovalid,
                  res.pc, res.status};
    end
  end

endmodule : subleq_machine_step
`default_nettype wire

/* tb/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the SUBLEQ command engine: a directed table, then
// random programs, each reply compared field by field with a local model or a typed-in expectation.
// ----------------------------------------------------------------------------
module tb;
  import slq_pkg::*;

  localparam int WINDOW         = 48;    // most programs live in the low words
  localparam int RANDOM_ITEMS   = 1450;
  localparam int WATCHDOG_LIMIT = 500;
  localparam int DRAIN_CYCLES   = 24;

  logic        clk;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  // [14:0] address, [30:15] write_data, [39:31] input_value
  logic [39:0] s_tdata  = '0;
  // [1:0] command
  logic [1:0]  s_tuser  = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  // [2:0] status, [17:3] program_counter, [18] output_valid,
  // [26:19] output_byte, [27] input_taken, [43:28] read_data, [47:44] zero
  logic [47:0] m_tdata;

  subleq_machine_step uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Local copy of the machine state.
  logic [15:0]     mem_q     [0:MEM_WORDS-1];
  bit              written_q [0:MEM_WORDS-1];
  logic [PC_W-1:0] pc_q      = '0;
  bit              halted_q  = 1'b0;

  result_t         pending_replies [$];
  logic [14:0]     far_addrs [$];
  int              fail_count     = 0;
  int              commands_sent  = 0;
  int              burst_left     = 0;
  int              ready_left     = 0;
  int              quiet_cycles   = 0;

  // One row of the directed table. When known is set, the reply fields are
  // typed in and used as the expectation instead of the model's answer.
  typedef struct packed {
    cmd_t        cmd;
    logic [14:0] addr;
    logic [15:0] wdata;
    logic [8:0]  ival;
    logic        known;
    status_t     status;
    logic [14:0] pc;
    logic [15:0] rdata;
  } drill_t;

  drill_t drill_q [$];

  // Applies one command to the local state and returns the reply.
  function automatic result_t subleq_execute(input cmd_t cmd, input logic [14:0] addr,
                                             input logic [15:0] wdata,
                                             input logic [8:0] ival);
    result_t     r;
    int          sa, sb, sc, npc, iv;
    logic [15:0] diff;
    bit          done;
    r = '0;
    r.status = ST_OK;
    done = 1'b0;
    case (cmd)
      CMD_WRITE: begin
        mem_q[addr] = wdata;
        written_q[addr] = 1'b1;
      end
      CMD_READ: r.rdata = mem_q[addr];
      CMD_RESTART: begin
        pc_q = '0;
        halted_q = 1'b0;
      end
      default: begin
        if (halted_q) begin
          r.status = ST_HALTED;
        end else if (pc_q >= PC_LIMIT) begin
          r.status = ST_PC_RANGE;
          halted_q = 1'b1;
        end else begin
          sa = $signed(mem_q[pc_q]);
          sb = $signed(mem_q[15'(pc_q + 15'd1)]);
          sc = $signed(mem_q[15'(pc_q + 15'd2)]);
          iv = $signed(ival);
          npc = pc_q;
          // A negative branch target is rejected before anything else.
          if (sc < 0) begin
            r.status = ST_BAD_ADDR;
          end else if (sa == -1 && sb == -1) begin
            r.status = ST_IO_FAULT;
          end else if (sa == -1) begin
            if (sb < 0 || sb >= MEM_WORDS) begin
              r.status = ST_BAD_ADDR;
            end else begin
              mem_q[sb] = 16'(iv);
              written_q[sb] = 1'b1;
              r.itaken = 1'b1;
              npc = (iv > 0) ? pc_q + 3 : sc;
              done = 1'b1;
            end
          end else if (sb == -1) begin
            if (sa < 0 || sa >= MEM_WORDS) begin
              r.status = ST_BAD_ADDR;
            end else begin
              r.ovalid = 1'b1;
              r.obyte = mem_q[sa][7:0];
              npc = pc_q + 3;
              done = 1'b1;
            end
          end else begin
            if (sa < 0 || sa >= MEM_WORDS || sb < 0 || sb >= MEM_WORDS) begin
              r.status = ST_BAD_ADDR;
            end else begin
              diff = mem_q[sb] - mem_q[sa];
              mem_q[sb] = diff;
              npc = ($signed(diff) > 0) ? pc_q + 3 : sc;
              done = 1'b1;
            end
          end
          // The step completes first; running into the limit halts afterwards.
          if (done) begin
            pc_q = (npc > PC_MAX) ? PC_MAX : PC_W'(npc);
            if (npc >= PC_LIMIT) r.status = ST_PC_RANGE;
          end
          if (r.status != ST_OK) halted_q = 1'b1;
        end
      end
    endcase
    r.pc = pc_q;
    return r;
  endfunction

  function automatic void row(input cmd_t cmd, input logic [14:0] addr,
                              input logic [15:0] wdata, input logic [8:0] ival,
                              input logic known, input status_t status,
                              input logic [14:0] pc, input logic [15:0] rdata);
    drill_t d;
    d.cmd    = cmd;
    d.addr   = addr;
    d.wdata  = wdata;
    d.ival   = ival;
    d.known  = known;
    d.status = status;
    d.pc     = pc;
    d.rdata  = rdata;
    drill_q.push_back(d);
  endfunction

  function automatic logic [8:0] input_byte();
    int r;
    r = $urandom_range(0, 99);
    if (r < 25) return 9'h1FF;
    if (r < 40) return 9'h000;
    return 9'($urandom_range(0, 256) - 1);
  endfunction

  // Mostly small signed values so that differences land on both signs.
  function automatic logic [15:0] data_word();
    if ($urandom_range(0, 9) < 6) return 16'($urandom_range(0, 80) - 40);
    return 16'($urandom);
  endfunction

  function automatic logic [15:0] operand_word();
    int r;
    r = $urandom_range(0, 99);
    if (r < 18) return WORD_M1;
    if (r < 21) return 16'(0 - $urandom_range(2, 32768));
    if (r < 25) return 16'($urandom_range(0, 32767));
    return 16'($urandom_range(0, WINDOW - 1));
  endfunction

  // Jump targets: mostly inside the window, now and then negative, far, or
  // at the top of memory where the fetch address wraps and pc hits the limit.
  function automatic logic [15:0] target_word();
    int r;
    r = $urandom_range(0, 99);
    if (r < 3) return 16'(0 - $urandom_range(1, 32768));
    if (r < 6) return 16'($urandom_range(32764, 32767));
    if (r < 8) return 16'($urandom_range(0, 32767));
    return 16'($urandom_range(0, WINDOW - 1));
  endfunction

  // Presents one command and holds it until the transfer happens. The sender
  // then either carries on with its burst or goes quiet for a while.
  task automatic send_command(input cmd_t cmd, input logic [14:0] addr,
                              input logic [15:0] wdata, input logic [8:0] ival,
                              input bit known, input result_t known_reply);
    result_t predicted;
    int      idle;
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= {ival, wdata, addr};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predicted = subleq_execute(cmd, addr, wdata, ival);
    pending_replies.push_back(known ? known_reply : predicted);
    commands_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = ($urandom_range(0, 5) == 0) ? 60 : $urandom_range(0, 12);
      idle = $urandom_range(0, 8);
      if (idle > 0) begin
        s_tvalid <= 1'b0;
        repeat (idle) @(posedge clk);
      end
    end
  endtask

  // Memory words are undefined until written, so every word the next step
  // may fetch (the instruction and both data operands) is written first.
  task automatic stage_step_operands();
    logic [14:0] at;
    int          sa, sb;
    for (int k = 0; k < 3; k++) begin
      at = 15'(pc_q + k);
      if (!written_q[at])
        send_command(CMD_WRITE, at, (k == 2) ? target_word() : operand_word(),
                     input_byte(), 1'b0, '0);
    end
    sa = $signed(mem_q[pc_q]);
    sb = $signed(mem_q[15'(pc_q + 15'd1)]);
    if (sa >= 0 && !written_q[sa])
      send_command(CMD_WRITE, 15'(sa), data_word(), input_byte(), 1'b0, '0);
    if (sb >= 0 && !written_q[sb])
      send_command(CMD_WRITE, 15'(sb), data_word(), input_byte(), 1'b0, '0);
  endtask

  task automatic compare_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %h, got %h", $time, name, want, got);
      fail_count++;
    end
  endtask

  // Receiver: alternating ready and stall runs, with an occasional long
  // stretch of steady readiness.
  always @(posedge clk) begin
    if (ready_left > 0) begin
      ready_left <= ready_left - 1;
    end else if (m_tready) begin
      m_tready   <= 1'b0;
      ready_left <= $urandom_range(0, 6);
    end else begin
      m_tready   <= 1'b1;
      ready_left <= ($urandom_range(0, 7) == 0) ? 60 : $urandom_range(0, 12);
    end
  end

  // Reply checker: every result transfer is matched against the oldest
  // outstanding expectation.
  always @(posedge clk) begin
    result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_replies.size() == 0) begin
        $display("%0t: unexpected result, expected none, got %h", $time, m_tdata);
        fail_count++;
      end else begin
        want = pending_replies.pop_front();
        compare_field("status", 16'(want.status), 16'(m_tdata[2:0]));
        compare_field("program_counter", 16'(want.pc), 16'(m_tdata[17:3]));
        compare_field("output_valid", 16'(want.ovalid), 16'(m_tdata[18]));
        compare_field("output_byte", 16'(want.obyte), 16'(m_tdata[26:19]));
        compare_field("input_taken", 16'(want.itaken), 16'(m_tdata[27]));
        compare_field("read_data", want.rdata, m_tdata[43:28]);
      end
    end
  end

  // Watchdog on cycles in which neither side completes a transfer.
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("tb: errors");
      $finish;
    end
  end

  initial begin
    result_t     typed_reply;
    logic [14:0] addr;
    int          pick;
    int          random_start;

    // Directed program. It walks input (end of input and a positive byte),
    // output, a wrapping subtract into the pc limit, a read while halted, a
    // step while halted, restart, a positive subtract, the I/O fault, a
    // negative operand address and a negative jump target.
    //   cmd          addr      wdata     ival    known status       pc        rdata
    row(CMD_WRITE,   15'h0000, 16'hFFFF, 9'h000, 1'b1, ST_OK,       15'h0000, 16'h0000);
    row(CMD_WRITE,   15'h0001, 16'h0005, 9'h000, 1'b0, ST_OK,       15'h0000, 16'h0000);
    row(CMD_WRITE,   15'h0002, 16'h0000, 9'h000, 1'b0, ST_OK,       15'h0000, 16'h0000);
    row(CMD_WRITE,   15'h0005, 16'h0000, 9'h000, 1'b0, ST_OK,       15'h0000, 16'h0000);
    row(CMD_STEP,    15'h7FFF, 16'hFFFF, 9'h1FF, 1'b0, ST_OK,       15'h0000, 16'h0000);
    row(CMD_STEP,    15'h0000, 16'h0000, 9'h0FF, 1'b0, ST_OK,       15'h0000, 16'h0000);
    row(CMD_WRITE,   15'h0003, 16'h0005, 9'h000, 1'b0, ST_OK,       15'h0000, 16'h0000);
    row(CMD_WRITE,   15'h0004, 16'hFFFF, 9'h000, 1'b0, ST_OK,       15'h0000, 16'h0000);
    row(CMD_STEP,    15'h0000, 16'h0000, 9'h000, 1'b0, ST_OK,       15'h0000, 16'h0000);
    row(CMD_WRITE,   15'h0006, 16'h0004, 9'h000, 1'b0, ST_OK,       15'h0000, 16'h0000);
    row(CMD_WRITE,   15'h0007, 16'h7FFF, 9'h000, 1'b0, ST_OK,       15'h0000, 16'h0000);
    row(CMD_WRITE,   15'h0008, 16'h7FFF, 9'h000, 1'b0, ST_OK,       15'h0000, 16'h0000);
    row(CMD_WRITE,   15'h7FFF, 16'h7FFF, 9'h1FF, 1'b0, ST_OK,       15'h0000, 16'h0000);
    row(CMD_STEP,    15'h0000, 16'h0000, 9'h000, 1'b1, ST_PC_RANGE, 15'h7FFF, 16'h0000);
    row(CMD_READ,    15'h7FFF, 16'h0000, 9'h000, 1'b1, ST_OK,       15'h7FFF, 16'h8000);
    row(CMD_STEP,    15'h0000, 16'h0000, 9'h000, 1'b1, ST_HALTED,   15'h7FFF, 16'h0000);
    row(CMD_RESTART, 15'h0000, 16'h0000, 9'h000, 1'b1, ST_OK,       15'h0000, 16'h0000);
    row(CMD_WRITE,   15'h0000, 16'h0004, 9'h000, 1'b0, ST_OK,       15'h0000, 16'h0000);
    row(CMD_STEP,    15'h0000, 16'h0000, 9'h000, 1'b0, ST_OK,       15'h0000, 16'h0000);
    row(CMD_WRITE,   15'h0003, 16'hFFFF, 9'h000, 1'b0, ST_OK,       15'h0000, 16'h0000);
    row(CMD_STEP,    15'h0000, 16'h0000, 9'h000, 1'b1, ST_IO_FAULT, 15'h0003, 16'h0000);
    row(CMD_RESTART, 15'h0000, 16'h0000, 9'h000, 1'b0, ST_OK,       15'h0000, 16'h0000);
    row(CMD_WRITE,   15'h0001, 16'hFFFE, 9'h000, 1'b0, ST_OK,       15'h0000, 16'h0000);
    row(CMD_STEP,    15'h0000, 16'h0000, 9'h000, 1'b1, ST_BAD_ADDR, 15'h0000, 16'h0000);
    row(CMD_RESTART, 15'h0000, 16'h0000, 9'h000, 1'b0, ST_OK,       15'h0000, 16'h0000);
    row(CMD_WRITE,   15'h0002, 16'h8000, 9'h000, 1'b0, ST_OK,       15'h0000, 16'h0000);
    row(CMD_STEP,    15'h0000, 16'h0000, 9'h000, 1'b1, ST_BAD_ADDR, 15'h0000, 16'h0000);

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    foreach (drill_q[i]) begin
      typed_reply        = '0;
      typed_reply.status = drill_q[i].status;
      typed_reply.pc     = drill_q[i].pc;
      typed_reply.rdata  = drill_q[i].rdata;
      send_command(drill_q[i].cmd, drill_q[i].addr, drill_q[i].wdata, drill_q[i].ival,
                   drill_q[i].known, typed_reply);
    end

    // Random programs. A halted machine is usually restarted; otherwise steps
    // dominate, mixed with code and data patches, far writes and reads.
    random_start = commands_sent;
    while (commands_sent - random_start < RANDOM_ITEMS) begin
      if (halted_q && $urandom_range(0, 9) < 7) begin
        send_command(CMD_RESTART, 15'($urandom), 16'($urandom), input_byte(), 1'b0, '0);
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 60) begin
          if (!halted_q) stage_step_operands();
          send_command(CMD_STEP, 15'($urandom), 16'($urandom), input_byte(), 1'b0, '0);
        end else if (pick < 76) begin
          addr = 15'($urandom_range(0, WINDOW - 1));
          case ($urandom_range(0, 2))
            0:       send_command(CMD_WRITE, addr, operand_word(), input_byte(), 1'b0, '0);
            1:       send_command(CMD_WRITE, addr, target_word(), input_byte(), 1'b0, '0);
            default: send_command(CMD_WRITE, addr, data_word(), input_byte(), 1'b0, '0);
          endcase
        end else if (pick < 81) begin
          addr = 15'($urandom);
          send_command(CMD_WRITE, addr, 16'($urandom), input_byte(), 1'b0, '0);
          if (far_addrs.size() < 32) far_addrs.push_back(addr);
        end else if (pick < 95) begin
          if (far_addrs.size() != 0 && $urandom_range(0, 3) == 0)
            addr = far_addrs[$urandom_range(0, far_addrs.size() - 1)];
          else
            addr = 15'($urandom_range(0, WINDOW - 1));
          if (!written_q[addr])
            send_command(CMD_WRITE, addr, data_word(), input_byte(), 1'b0, '0);
          send_command(CMD_READ, addr, 16'($urandom), input_byte(), 1'b0, '0);
        end else begin
          send_command(CMD_RESTART, 15'($urandom), 16'($urandom), input_byte(), 1'b0, '0);
        end
      end
    end

    s_tvalid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0)
      $display("tb: clean");
    else
      $display("tb: errors");
    $finish;
  end

endmodule
